// ===== design/lru_page_replacement_macros.svh =====
// assertion macros shared by the lru page replacement design
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// same-cycle implication, checked outside reset
`define LRUPR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define LRUPR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/lrupr_pkg.sv =====
// constants, types and helpers shared by the lru page replacement modules
`default_nettype none

package lrupr_pkg;

	localparam int FRAMES    = 16;
	localparam int PAGE_BITS = 16;
	localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W     = $clog2(FRAMES + 1);
	localparam int CFG_W     = 5;
	localparam int FIDX_W    = 4;
	localparam int TOTAL_W   = 32;

	localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [PAGE_BITS-1:0] page_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} lrupr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
	} lrupr_status_t;

	// zero acts as one, anything above the frame count acts as the frame count
	function automatic cnt_t clamp_frames(logic [CFG_W-1:0] v);
		cnt_t r;
		if (v == '0) begin
			r = cnt_t'(1);
		end else if (32'(v) > FRAMES) begin
			r = cnt_t'(FRAMES);
		end else begin
			r = cnt_t'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/lrupr_ctrl.sv =====
// sequencer for the lru page replacement unit: accept, scan frames, commit
`default_nettype none

module lrupr_ctrl (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_stall,
	output logic                       out_valid,
	input  wire                        out_stall,
	input  lrupr_pkg::lrupr_status_t   status,
	output lrupr_pkg::lrupr_cmd_t      cmd
);
	import lrupr_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load   = (state_q == S_IDLE) && in_valid;
		cmd.step   = (state_q == S_SCAN);
		cmd.commit = (state_q == S_COMMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a commit refills the output word in the cycle it is taken
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (status.scan_last) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					// wait until the output word has room
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`include "lru_page_replacement_macros.svh"

	`LRUPR_ASSERT_NOW(a_commit_room, clk, arst_n, cmd.commit, !out_valid_q || !out_stall, "commit while output word is held")
	`LRUPR_ASSERT_NXT(a_accept_busy, clk, arst_n, in_valid && !in_stall, in_stall && cmd.step, "no scan after accepted word")
	`LRUPR_ASSERT_NXT(a_commit_out, clk, arst_n, cmd.commit, out_valid, "committed result not presented")
	`LRUPR_ASSERT_NOW(a_one_cmd, clk, arst_n, 1'b1, $onehot0({cmd.load, cmd.step, cmd.commit}), "overlapping commands")

endmodule

`default_nettype wire

// ===== design/lrupr_dp.sv =====
// frame store, recency ranks, scan registers and result registers
`default_nettype none

module lrupr_dp (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [lrupr_pkg::CFG_W-1:0]      frames_in_use,
	input  wire  [lrupr_pkg::PAGE_BITS-1:0]  page,
	input  lrupr_pkg::lrupr_cmd_t            cmd,
	output lrupr_pkg::lrupr_status_t         status,
	output logic                             fault,
	output logic [lrupr_pkg::FIDX_W-1:0]     frame_index,
	output logic                             evicted_valid,
	output logic [lrupr_pkg::PAGE_BITS-1:0]  evicted_page,
	output logic [lrupr_pkg::TOTAL_W-1:0]    fault_total
);
	import lrupr_pkg::*;

	page_t frame_page_q [FRAMES];
	logic  [FRAMES-1:0] frame_valid_q;
	idx_t  frame_rank_q [FRAMES];
	cnt_t  active_q;
	logic  [TOTAL_W-1:0] fault_total_q;

	// scan registers
	page_t page_q;
	idx_t  idx_q;
	logic  hit_found_q;
	idx_t  hit_idx_q;
	idx_t  hit_rank_q;
	logic  free_found_q;
	idx_t  free_idx_q;
	idx_t  vic_idx_q;
	idx_t  vic_rank_q;
	page_t vic_page_q;

	// result registers
	logic              fault_q;
	logic [FIDX_W-1:0] frame_index_q;
	logic              evicted_valid_q;
	page_t             evicted_page_q;

	page_t        cur_page;
	logic         cur_valid;
	idx_t         cur_rank;
	idx_t         sel_idx;
	logic         was_valid;
	idx_t         old_rank;
	logic         evict;
	logic [31:0]  sel_wide;

	assign cur_page  = frame_page_q[idx_q];
	assign cur_valid = frame_valid_q[idx_q];
	assign cur_rank  = frame_rank_q[idx_q];

	assign status.scan_last = ((CNT_W + 1)'(idx_q) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(active_q);

	always_comb begin
		evict = !hit_found_q && !free_found_q;
		priority if (hit_found_q) begin
			sel_idx  = hit_idx_q;
			old_rank = hit_rank_q;
		end else if (free_found_q) begin
			sel_idx  = free_idx_q;
			old_rank = vic_rank_q;
		end else begin
			sel_idx  = vic_idx_q;
			old_rank = vic_rank_q;
		end
		// a free frame was not valid, so every valid frame ages
		was_valid = !free_found_q || hit_found_q;
		sel_wide  = 32'(sel_idx);
	end

	// scan: one frame a cycle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_q       <= page;
			idx_q        <= '0;
			hit_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd.step) begin
			idx_q <= idx_q + idx_t'(1);
			if (!hit_found_q && cur_valid && (cur_page == page_q)) begin
				hit_found_q <= 1'b1;
				hit_idx_q   <= idx_q;
				hit_rank_q  <= cur_rank;
			end
			if (!free_found_q && !cur_valid) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_q;
			end
			if ((idx_q == '0) || (cur_rank > vic_rank_q)) begin
				vic_idx_q  <= idx_q;
				vic_rank_q <= cur_rank;
				vic_page_q <= cur_page;
			end
		end
	end

	// frame contents and result word
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (!hit_found_q) begin
				frame_page_q[sel_idx] <= page_q;
			end
			fault_q         <= !hit_found_q;
			frame_index_q   <= sel_wide[FIDX_W-1:0];
			evicted_valid_q <= evict;
			evicted_page_q  <= evict ? vic_page_q : '0;
		end
	end

	// recency ranks, valid bits, frame count and fault counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				frame_rank_q[i] <= '0;
			end
			active_q      <= clamp_frames(FRAMES_RESET);
			fault_total_q <= '0;
		end else if (cfg_we) begin
			frame_valid_q <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				frame_rank_q[i] <= '0;
			end
			active_q <= clamp_frames(frames_in_use);
		end else if (cmd.commit) begin
			for (int i = 0; i < FRAMES; i++) begin
				if (idx_t'(i) == sel_idx) begin
					frame_rank_q[i] <= '0;
				end else if (frame_valid_q[i] &&
				             (!was_valid || (frame_rank_q[i] < old_rank))) begin
					frame_rank_q[i] <= frame_rank_q[i] + idx_t'(1);
				end
			end
			frame_valid_q[sel_idx] <= 1'b1;
			if (!hit_found_q && (fault_total_q != '1)) begin
				fault_total_q <= fault_total_q + TOTAL_W'(1);
			end
		end
	end

	assign fault         = fault_q;
	assign frame_index   = frame_index_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_page  = evicted_page_q;
	assign fault_total   = fault_total_q;

`include "lru_page_replacement_macros.svh"

	`LRUPR_ASSERT_NXT(a_total_mono, clk, arst_n, 1'b1, fault_total_q >= $past(fault_total_q), "fault total went down")
	`LRUPR_ASSERT_NXT(a_miss_counts, clk, arst_n, cmd.commit && !hit_found_q, fault_total_q != '0 && fault_q, "miss not counted")
	`LRUPR_ASSERT_NXT(a_evict_fault, clk, arst_n, cmd.commit, !evicted_valid_q || fault_q, "eviction without fault")
	`LRUPR_ASSERT_NXT(a_sel_valid, clk, arst_n, cmd.commit && !cfg_we, frame_valid_q[$past(sel_idx)], "used frame not valid")

endmodule

`default_nettype wire

// ===== design/lru_page_replacement.sv =====
// lru page replacement unit: top level joining controller and datapath
//
//   channel  | handshake             | word
//   ---------+-----------------------+-----------------------------------------------
//   in       | in_valid / in_stall   | page
//   out      | out_valid / out_stall | fault, frame_index, evicted_valid,
//            |                       | evicted_page, fault_total
//   cfg      | cfg_we                | frames_in_use
//
// a word passes an accept state, a scan over the N active frames
// through a single compare unit, and a commit state that updates all
// ranks at once.
// a new word is taken while the previous result waits in the output register;
// commit holds while that register is full and stalled.
// reset empties all frames, clears the fault count and sets 16 frames;
// a cfg write empties all frames and keeps the fault count.
`default_nettype none

module lru_page_replacement (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [lrupr_pkg::CFG_W-1:0]      frames_in_use,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire  [lrupr_pkg::PAGE_BITS-1:0]  page,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic                             fault,
	output logic [lrupr_pkg::FIDX_W-1:0]     frame_index,
	output logic                             evicted_valid,
	output logic [lrupr_pkg::PAGE_BITS-1:0]  evicted_page,
	output logic [lrupr_pkg::TOTAL_W-1:0]    fault_total
);
	import lrupr_pkg::*;

	lrupr_cmd_t    cmd;
	lrupr_status_t status;

	lrupr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	lrupr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.frames_in_use (frames_in_use),
		.page          (page),
		.cmd           (cmd),
		.status        (status),
		.fault         (fault),
		.frame_index   (frame_index),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.fault_total   (fault_total)
	);

endmodule

`default_nettype wire
